>>> hdl/pcx_rle_row_decoder_unit_macros.svh
// assertion macros for the pcx run-length row decoder
`ifndef PCX_RLE_ROW_DECODER_UNIT_MACROS_SVH
`define PCX_RLE_ROW_DECODER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PCX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PCX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pcx_rle_pkg.sv
// shared types and constants of the pcx run-length row decoder
`default_nettype none

package pcx_rle_pkg;

    localparam int BYTE_W = 8;
    localparam int RUN_W  = 6;
    localparam int BPL_W  = 15;

    localparam logic [BPL_W-1:0]  BPL_RESET   = 15'd640;
    localparam logic [BYTE_W-1:0] MARKER_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] COUNT_MASK  = 8'h3F;

    localparam int CMDQ_DEPTH = 2;

    // one queued command: a value and how many pixels it makes (1..63)
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [RUN_W-1:0]  count;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

>>> hdl/pcx_rle_row_decoder_unit.sv
// top level of the pcx run-length row decoder
//
//  channel  | direction | handshake           | contents
//  s_*      | in        | s_tvalid / s_tready | s_tdata[7:0] = data_byte
//  m_*      | out       | m_tvalid / m_tready | m_tdata[7:0] = pixel, tlast, tuser
//  cfg_*    | in        | cfg_valid/cfg_ready | cfg_data[14:0] = bytes_per_line
//
// literal and marker bytes are taken one per cycle while the queue has room; a run
// of n pixels leaves the output register one pixel a cycle while m_tready is high
// the command queue holds two entries by default; input stalls only when it is full
// reset: bytes_per_line = 640, no marker pending, output empty
// the output register holds its word until m_tready is seen
// a config word is taken only while the queue and output register are empty
`default_nettype none

`include "pcx_rle_row_decoder_unit_macros.svh"

module pcx_rle_row_decoder_unit
    import pcx_rle_pkg::*;
#(
    parameter int QUEUE_DEPTH = CMDQ_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // [7:0] data_byte
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata,   // [7:0] pixel
    output logic                  m_tlast,   // last_of_run
    output logic                  m_tuser,   // [0] row_end
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [BPL_W-1:0] cfg_data
);

    cmd_t    push_cmd;
    cmd_t    head;
    q_stat_t q_stat;
    logic    push;
    logic    pop;
    logic    cfg_we;

    // the row length is only reconfigured once every queued pixel is out
    assign cfg_ready = q_stat.empty && !m_tvalid;
    assign cfg_we    = cfg_valid && cfg_ready;

    pcx_rle_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    pcx_rle_cmdq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    pcx_rle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_bpl   (cfg_data),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (m_tdata),
        .out_last  (m_tlast),
        .out_end   (m_tuser)
    );

    `PCX_ASSERT_NOW(a_q_full_empty, clk, rst_n, 1'b1,
        !(q_stat.full && q_stat.empty), "queue both full and empty")
    `PCX_ASSERT_NOW(a_pop_nonempty, clk, rst_n, pop, !q_stat.empty, "pop from empty queue")
    `PCX_ASSERT_NEXT(a_row_end_once, clk, rst_n, m_tvalid && m_tready && m_tuser && !m_tlast,
        !(m_tvalid && m_tuser), "row end flagged twice in one run")

endmodule

`default_nettype wire

>>> hdl/pcx_rle_front.sv
// front end: takes encoded bytes, holds run markers, issues commands
`default_nettype none

module pcx_rle_front
    import pcx_rle_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire q_stat_t           q_stat,
    output logic                   push,
    output cmd_t                   push_cmd
);

    logic             pending_reg, pending_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic             accept;
    logic             is_marker;

    assign in_ready  = !q_stat.full;
    assign accept    = in_valid && in_ready;
    // a byte right after a marker is always a value
    assign is_marker = !pending_reg && ((in_byte & MARKER_MASK) == MARKER_MASK);

    always_comb
    begin
        pending_next   = pending_reg;
        run_next       = run_reg;
        push           = 1'b0;
        push_cmd.value = in_byte;
        push_cmd.count = RUN_W'(1);
        if (pending_reg && (run_reg > RUN_W'(1)))
        begin
            push_cmd.count = run_reg;
        end
        if (accept)
        begin
            if (is_marker)
            begin
                pending_next = 1'b1;
                run_next     = RUN_W'(in_byte & COUNT_MASK);
            end
            else
            begin
                pending_next = 1'b0;
                run_next     = '0;
                push         = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            run_reg     <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            run_reg     <= run_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/pcx_rle_cmdq.sv
// short command queue between front and back end
`default_nettype none

module pcx_rle_cmdq
    import pcx_rle_pkg::*;
#(
    parameter int DEPTH = CMDQ_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output q_stat_t   stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/pcx_rle_back.sv
// back end: expands commands into pixels and tracks the scanline
`default_nettype none

module pcx_rle_back
    import pcx_rle_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [BPL_W-1:0] cfg_bpl,
    input  wire cmd_t             head,
    input  wire q_stat_t          q_stat,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [BYTE_W-1:0]     out_pixel,
    output logic                  out_last,
    output logic                  out_end
);

    logic [BPL_W-1:0]  bpl_reg, bpl_next;
    logic [BPL_W-1:0]  row_left_reg, row_left_next;
    logic [RUN_W-1:0]  cnt_reg, cnt_next;
    logic              ended_reg, ended_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] pixel_reg, pixel_next;
    logic              last_reg, last_next;
    logic              end_reg, end_next;
    logic              fire;
    logic              is_last;
    logic              end_px;

    assign fire    = !q_stat.empty && (!valid_reg || out_ready);
    assign is_last = ((cnt_reg + RUN_W'(1)) == head.count);
    // a counter of zero acts as one
    assign end_px  = !ended_reg && (row_left_reg <= BPL_W'(1));
    assign pop     = fire && is_last;

    always_comb
    begin
        bpl_next      = bpl_reg;
        row_left_next = row_left_reg;
        cnt_next      = cnt_reg;
        ended_next    = ended_reg;
        valid_next    = valid_reg;
        pixel_next    = pixel_reg;
        last_next     = last_reg;
        end_next      = end_reg;
        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end
        if (fire)
        begin
            valid_next = 1'b1;
            pixel_next = head.value;
            last_next  = is_last;
            end_next   = end_px;
            if (is_last)
            begin
                cnt_next   = '0;
                ended_next = 1'b0;
                // reload once the row has ended, overshoot is dropped
                if (ended_reg || end_px)
                begin
                    row_left_next = bpl_reg;
                end
                else
                begin
                    row_left_next = row_left_reg - BPL_W'(1);
                end
            end
            else
            begin
                cnt_next   = cnt_reg + RUN_W'(1);
                ended_next = ended_reg || end_px;
                if (!ended_reg && !end_px)
                begin
                    row_left_next = row_left_reg - BPL_W'(1);
                end
            end
        end
        if (cfg_we)
        begin
            bpl_next      = cfg_bpl;
            row_left_next = cfg_bpl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpl_reg      <= BPL_RESET;
            row_left_reg <= BPL_RESET;
            cnt_reg      <= '0;
            ended_reg    <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            bpl_reg      <= bpl_next;
            row_left_reg <= row_left_next;
            cnt_reg      <= cnt_next;
            ended_reg    <= ended_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
        last_reg  <= last_next;
        end_reg   <= end_next;
    end

    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;
    assign out_last  = last_reg;
    assign out_end   = end_reg;

endmodule

`default_nettype wire
